// ----- hdl/pal_pkg.sv -----
// Shared types and constants for the positional array list.
// Holds the request mode codes, result status codes, controller states
// and the result record. Depends on nothing.
package pal_pkg;

  localparam int DEFAULT_CAPACITY = 128;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    MODE_GET    = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_LOCATE = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BADPOS   = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET_WAIT,
    ST_DEL_WAIT,
    ST_SHIFT_DN,
    ST_SHIFT_UP,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [6:0]  found_position;
    logic [7:0]  list_count;
  } pal_result_t;

endpackage

// ----- hdl/pal_if.sv -----
// Valid/ready channel interfaces for list requests and list results.
// Standalone; no package dependency.
interface pal_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [7:0]         position;
  logic signed [31:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface pal_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [6:0]         found_position;
  logic [7:0]         list_count;

  modport source (output valid, status, read_value, found_position, list_count,
                  input ready);
  modport sink   (input valid, status, read_value, found_position, list_count,
                  output ready);
endinterface

// ----- hdl/pal_mem.sv -----
// Word store of the list: one read port and one write port, registered read.
// Depends on pal_pkg for the word width.
module pal_mem #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [pal_pkg::DATA_W-1:0] rdata,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [pal_pkg::DATA_W-1:0] wdata
);
  import pal_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/pal_ctrl.sv -----
// Request sequencer: decodes a request, walks the word store to shift or
// search, and keeps the entry count. Depends on pal_pkg.
module pal_ctrl #(
  parameter int CAPACITY = 128,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic [2:0]                 req_mode,
  input  logic [7:0]                 req_position,
  input  logic signed [31:0]         req_value,
  output logic                       res_valid,
  input  logic                       res_ready,
  output pal_pkg::pal_result_t       res,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [pal_pkg::DATA_W-1:0] mem_rdata,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [pal_pkg::DATA_W-1:0] mem_wdata
);
  import pal_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 8) ? CW : 8;
  localparam int XW = (AW > 7) ? AW : 7;

  state_t            state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [CW-1:0]     rem, rem_next;
  logic [AW-1:0]     rp, rp_next;
  logic [AW-1:0]     wa, wa_next;
  logic              pend, pend_next;
  logic [AW-1:0]     opos, opos_next;
  logic [DATA_W-1:0] oval, oval_next;
  pal_result_t       rslt, rslt_next;

  logic [PW-1:0]     pos_w;
  logic [PW-1:0]     cnt_w;
  logic [XW-1:0]     fpos_w;
  logic [PW-1:0]     lcnt_w;

  assign pos_w  = PW'(req_position);
  assign cnt_w  = PW'(cnt);
  assign fpos_w = XW'(wa);
  assign lcnt_w = PW'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    rem  <= rem_next;
    rp   <= rp_next;
    wa   <= wa_next;
    opos <= opos_next;
    oval <= oval_next;
    rslt <= rslt_next;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    rem_next   = rem;
    rp_next    = rp;
    wa_next    = wa;
    pend_next  = pend;
    opos_next  = opos;
    oval_next  = oval;
    rslt_next  = rslt;
    mem_re     = 1'b0;
    mem_raddr  = rp;
    mem_we     = 1'b0;
    mem_waddr  = wa;
    mem_wdata  = mem_rdata;
    req_ready  = (state == ST_IDLE);
    res_valid  = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          rslt_next = '{status: STAT_OK, read_value: '0, found_position: '0,
                        list_count: '0};
          oval_next = req_value;
          opos_next = AW'(pos_w);
          pend_next = 1'b0;
          state_next = ST_DONE;
          case (req_mode)
            MODE_GET: begin
              if (pos_w >= cnt_w) begin
                rslt_next.status = STAT_BADPOS;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(pos_w);
                state_next = ST_GET_WAIT;
              end
            end
            MODE_INSERT: begin
              if (pos_w > cnt_w) begin
                rslt_next.status = STAT_BADPOS;
              end else if (cnt_w >= PW'(CAPACITY)) begin
                rslt_next.status = STAT_FULL;
              end else begin
                rp_next    = AW'(cnt_w - PW'(1));
                rem_next   = CW'(cnt_w - pos_w);
                state_next = ST_SHIFT_UP;
              end
            end
            MODE_DELETE: begin
              if (pos_w >= cnt_w) begin
                rslt_next.status = STAT_BADPOS;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(pos_w);
                rp_next    = AW'(pos_w + PW'(1));
                rem_next   = CW'(cnt_w - pos_w - PW'(1));
                state_next = ST_DEL_WAIT;
              end
            end
            MODE_CLEAR: begin
              cnt_next = '0;
            end
            MODE_LOCATE: begin
              rp_next    = '0;
              rem_next   = cnt;
              state_next = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_GET_WAIT: begin
        rslt_next.read_value = mem_rdata;
        state_next = ST_DONE;
      end

      ST_DEL_WAIT: begin
        rslt_next.read_value = mem_rdata;
        state_next = ST_SHIFT_DN;
      end

      // Each read at rp lands one place lower on the following cycle.
      ST_SHIFT_DN: begin
        if (pend) begin
          mem_we = 1'b1;
        end
        if (rem != '0) begin
          mem_re    = 1'b1;
          wa_next   = rp - AW'(1);
          rp_next   = rp + AW'(1);
          rem_next  = rem - CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          cnt_next   = cnt - CW'(1);
          state_next = ST_DONE;
        end
      end

      // Walks from the tail downward; the new word goes in once the gap is open.
      ST_SHIFT_UP: begin
        if (rem != '0) begin
          mem_we    = pend;
          mem_re    = 1'b1;
          wa_next   = rp + AW'(1);
          rp_next   = rp - AW'(1);
          rem_next  = rem - CW'(1);
          pend_next = 1'b1;
        end else if (pend) begin
          mem_we    = 1'b1;
          pend_next = 1'b0;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = opos;
          mem_wdata  = oval;
          cnt_next   = cnt + CW'(1);
          state_next = ST_DONE;
        end
      end

      ST_SCAN: begin
        if (pend && (mem_rdata == oval)) begin
          rslt_next.found_position = fpos_w[6:0];
          pend_next  = 1'b0;
          state_next = ST_DONE;
        end else if (rem == '0) begin
          rslt_next.status = STAT_NOTFOUND;
          pend_next  = 1'b0;
          state_next = ST_DONE;
        end else begin
          mem_re    = 1'b1;
          wa_next   = rp;
          rp_next   = rp + AW'(1);
          rem_next  = rem - CW'(1);
          pend_next = 1'b1;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res            = rslt;
    res.list_count = lcnt_w[7:0];
  end

endmodule

// ----- hdl/positional_array_list.sv -----
// Positional array list: an ordered list of signed 32-bit words held in a
// store of CAPACITY entries with an entry count. Each request selects get,
// insert, delete, clear or locate and produces exactly one result carrying a
// status, the word read or removed, the first matching position for locate,
// and the entry count after the request. The block takes one request at a
// time; the result then sits in an output register, so the next request is
// accepted while an earlier result still waits to be taken. Timing is set by
// the word store, which is touched one entry per cycle: get reads one entry,
// insert shifts the entries from the position on up by one, delete shifts
// those above it down by one, and locate reads entries from the head until
// the first match. The store comes out of reset with undefined contents,
// harmless as only entries below the count are read; no clearing is needed.
module positional_array_list #(
  parameter int CAPACITY = pal_pkg::DEFAULT_CAPACITY
) (
  input logic        clk,
  input logic        rst,
  pal_req_if.sink    req,
  pal_rsp_if.source  rsp
);
  import pal_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic              res_valid;
  logic              res_ready;
  pal_result_t       res;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  logic              out_valid;
  pal_result_t       out_res;

  // Sequencer: decodes each request and drives the store ports.
  pal_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_mode     (req.mode),
    .req_position (req.position),
    .req_value    (req.value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata)
  );

  // Word store with one read and one write each cycle.
  pal_mem #(.DEPTH(CAPACITY)) u_mem (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  // The output register takes a new result whenever it is empty or being
  // drained in the same cycle.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_res.status;
  assign rsp.read_value     = $signed(out_res.read_value);
  assign rsp.found_position = out_res.found_position;
  assign rsp.list_count     = out_res.list_count;

endmodule

// ----- hdl/pal_checker.sv -----
// Port-level checks on the positional array list result channel, plus the
// bind that attaches them to the top level. Depends on pal_pkg.
module pal_checker #(
  parameter int CAPACITY = 128
) (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic [31:0] rsp_read_value,
  input logic [6:0]  rsp_found_position,
  input logic [7:0]  rsp_list_count
);
  import pal_pkg::*;

  // A stalled result keeps its status, word and count.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_read_value) && $stable(rsp_list_count))
    else $error("result changed while stalled");

  // No result leaves the block right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A full store is only reported when the count is at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STAT_FULL) |-> rsp_list_count == 8'(CAPACITY))
    else $error("store full reported below capacity");

  // A failed search carries no word and no position.
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STAT_NOTFOUND)
      |-> (rsp_found_position == '0) && (rsp_read_value == '0))
    else $error("not-found result carries data");

  // Only a successful get or delete returns a word.
  a_word_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_read_value != '0) |-> rsp_status == STAT_OK)
    else $error("word returned with error status");

endmodule

bind positional_array_list pal_checker #(.CAPACITY(CAPACITY)) u_pal_checker (
  .clk                (clk),
  .rst                (rst),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_read_value     (rsp.read_value),
  .rsp_found_position (rsp.found_position),
  .rsp_list_count     (rsp.list_count)
);

// ----- tb/sv/positional_array_list_tb.sv -----
// Self-checking testbench for positional_array_list: drives list requests over
// the valid/ready request channel and checks every result against a predictor.
// Depends on pal_pkg and the pal_req_if / pal_rsp_if interfaces.
module positional_array_list_tb;
  import pal_pkg::*;

  localparam int CAP = DEFAULT_CAPACITY;
  localparam int RANDOM_ITEMS = 1750;
  // The slowest request walks the whole store. With sender gaps and receiver
  // stalls a full run stays far below this bound.
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 200;

  // The predictor keeps its own copy of the list and a queue of the results
  // that accepted requests must still produce, oldest first.
  class list_tracker;
    logic [31:0] slots [CAP];
    int unsigned list_len;
    pal_result_t owed_results[$];
    int unsigned mismatches;

    function new();
      list_len = 0;
      mismatches = 0;
    endfunction

    // Works out the result of one accepted request and updates the list.
    function void note_request(logic [2:0] mode, logic [7:0] pos, logic [31:0] val);
      pal_result_t r;
      int j;
      r = '0;
      r.status = STAT_OK;
      case (mode)
        MODE_GET: begin
          if (pos >= list_len) r.status = STAT_BADPOS;
          else r.read_value = slots[pos];
        end
        MODE_INSERT: begin
          if (pos > list_len) begin
            r.status = STAT_BADPOS;
          end else if (list_len >= CAP) begin
            r.status = STAT_FULL;
          end else begin
            for (j = list_len; j > pos; j--) slots[j] = slots[j-1];
            slots[pos] = val;
            list_len++;
          end
        end
        MODE_DELETE: begin
          if (pos >= list_len) begin
            r.status = STAT_BADPOS;
          end else begin
            r.read_value = slots[pos];
            for (j = pos; j + 1 < list_len; j++) slots[j] = slots[j+1];
            list_len--;
          end
        end
        MODE_CLEAR: list_len = 0;
        MODE_LOCATE: begin
          r.status = STAT_NOTFOUND;
          for (j = 0; j < list_len; j++) begin
            if (slots[j] == val) begin
              r.status = STAT_OK;
              r.found_position = j[6:0];
              break;
            end
          end
        end
        default: ;
      endcase
      r.list_count = list_len[7:0];
      owed_results.push_back(r);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0h, got %0h", field, want, got);
    endfunction

    // Compares one result taken from the block with the oldest owed result.
    function void check_result(pal_result_t got);
      pal_result_t want;
      if (owed_results.size() == 0) begin
        report("unexpected result status", '0, got.status);
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.read_value !== want.read_value)
        report("read_value", want.read_value, got.read_value);
      if (got.found_position !== want.found_position)
        report("found_position", want.found_position, got.found_position);
      if (got.list_count !== want.list_count)
        report("list_count", want.list_count, got.list_count);
    endfunction
  endclass

  logic clk;
  logic rst;
  pal_req_if req_ch();
  pal_rsp_if rsp_ch();

  positional_array_list u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  list_tracker tracker;
  int unsigned cycle_count;
  int sent;
  // When set, neither the sender nor the receiver inserts any idle cycles.
  bit quiet;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The timeout guards against a hung handshake anywhere in the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver stalls at random with a probability of 0.19, except during the
  // quiet stretch. Ready changes only at the falling edge.
  always @(negedge clk) begin
    rsp_ch.ready = quiet || ($urandom_range(0, 99) >= 19);
  end

  // Results are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    pal_result_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status = status_t'(rsp_ch.status);
      got.read_value = rsp_ch.read_value;
      got.found_position = rsp_ch.found_position;
      got.list_count = rsp_ch.list_count;
      tracker.check_result(got);
    end
  end

  // Presents one request and holds it until the block accepts it. Random idle
  // cycles may come first, during which the payload carries noise.
  task automatic send_request(logic [2:0] mode, logic [7:0] pos, logic [31:0] val);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 19) begin
      req_ch.valid = 1'b0;
      req_ch.mode = 3'($urandom);
      req_ch.position = 8'($urandom);
      req_ch.value = $urandom;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.mode = mode;
    req_ch.position = pos;
    req_ch.value = val;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(mode, pos, val);
    // Unused modes leave the list alone, so they do not count as work.
    if (mode <= MODE_LOCATE) sent++;
  endtask

  // Word values lean toward the extremes and a small pool, so that locate
  // sees duplicates and the sign bit is exercised often.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3, 4: return 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  // A locate value is usually a word that is already in the list.
  function automatic logic [31:0] pick_search();
    if (tracker.list_len > 0 && $urandom_range(0, 2) != 0)
      return tracker.slots[$urandom_range(0, tracker.list_len - 1)];
    return pick_word();
  endfunction

  // Positions mostly stay near the valid range; now and then any 8-bit value.
  function automatic logic [7:0] pick_position();
    if ($urandom_range(0, 99) < 15) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, tracker.list_len));
  endfunction

  task automatic mixed_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) send_request(MODE_INSERT, pick_position(), pick_word());
    else if (r < 55) send_request(MODE_GET, pick_position(), $urandom);
    else if (r < 75) send_request(MODE_DELETE, pick_position(), $urandom);
    else if (r < 93) send_request(MODE_LOCATE, 8'($urandom), pick_search());
    else if (r < 95) send_request(MODE_CLEAR, 8'($urandom), $urandom);
    else send_request(3'($urandom_range(5, 7)), 8'($urandom), $urandom);
  endtask

  initial begin
    int n;
    tracker = new();
    cycle_count = 0;
    sent = 0;
    quiet = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_GET;
    req_ch.position = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. The empty list rejects get and delete, finds nothing,
    // and refuses an insert beyond the end.
    send_request(MODE_GET, 8'd0, 32'd0);
    send_request(MODE_DELETE, 8'd0, 32'd0);
    send_request(MODE_LOCATE, 8'd0, 32'd0);
    send_request(MODE_INSERT, 8'd1, 32'd5);
    // Build a short list with the extreme words, inserting at head and tail.
    send_request(MODE_INSERT, 8'd0, 32'h8000_0000);
    send_request(MODE_INSERT, 8'd1, 32'h7fff_ffff);
    send_request(MODE_INSERT, 8'd0, 32'hffff_ffff);
    send_request(MODE_INSERT, 8'd1, 32'hffff_ffff);
    send_request(MODE_INSERT, 8'd255, 32'd1);
    send_request(MODE_GET, 8'd0, 32'd0);
    send_request(MODE_GET, 8'd3, 32'd0);
    send_request(MODE_GET, 8'd4, 32'd0);
    send_request(MODE_GET, 8'd255, 32'd0);
    // Locate must report the first of two equal words.
    send_request(MODE_LOCATE, 8'd0, 32'hffff_ffff);
    send_request(MODE_LOCATE, 8'd0, 32'h7fff_ffff);
    send_request(MODE_LOCATE, 8'd0, 32'd12345);
    send_request(MODE_DELETE, 8'd1, 32'd0);
    send_request(MODE_DELETE, 8'd255, 32'd0);
    // Unused modes change nothing and report the current count.
    send_request(3'd5, 8'd0, 32'd0);
    send_request(3'd6, 8'd255, 32'hffff_ffff);
    send_request(3'd7, 8'd1, 32'd1);
    send_request(MODE_CLEAR, 8'd0, 32'd0);
    send_request(MODE_GET, 8'd0, 32'd0);
    send_request(MODE_LOCATE, 8'd0, 32'hffff_ffff);

    // Random part, built from episodes: runs of mixed requests, a fill to a
    // full store followed by refused inserts, and a drain down to empty.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet = (sent >= 700 && sent < 1000);
      case ($urandom_range(0, 9))
        0: begin
          while (tracker.list_len < CAP)
            send_request(MODE_INSERT, 8'($urandom_range(0, tracker.list_len)), pick_word());
          // At a full store the position check still comes first.
          send_request(MODE_INSERT, 8'(CAP), pick_word());
          send_request(MODE_INSERT, 8'($urandom_range(0, CAP - 1)), pick_word());
          send_request(MODE_INSERT, 8'($urandom_range(CAP + 1, 255)), pick_word());
          send_request(MODE_LOCATE, 8'($urandom), pick_search());
          send_request(MODE_GET, 8'(CAP - 1), $urandom);
        end
        1: begin
          while (tracker.list_len > 0) begin
            if ($urandom_range(0, 3) == 0)
              send_request(MODE_LOCATE, 8'($urandom), pick_search());
            send_request(MODE_DELETE, 8'($urandom_range(0, tracker.list_len - 1)), $urandom);
          end
          send_request(MODE_DELETE, 8'd0, $urandom);
        end
        default: begin
          for (n = 0; n < 20; n++) mixed_request();
        end
      endcase
    end
    quiet = 1'b0;

    @(negedge clk);
    req_ch.valid = 1'b0;
    while (tracker.owed_results.size() != 0) @(posedge clk);
    // Give the block time to show any stray result before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
